@@ rtl/core/ppre_pkg.sv @@
package ppre_pkg;

  localparam int unsigned NUM_BINS_DEF   = 16;
  localparam int unsigned COUNT_BITS_DEF = 20;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned LN_W       = 32;
  localparam int unsigned FRAC_STEPS = 24;

  // ln(2) in Q0.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE  = 2'd1;
  localparam logic [1:0] FUNC_COMPUTE = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DEN = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
  } ln_req_t;

endpackage

@@ rtl/core/ppre_ln.sv @@
module ppre_ln import ppre_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ln_req_t                req_i,
  output logic                   done_o,
  output logic signed [LN_W-1:0] ln_o
);

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_SCALE, L_ROUND} state_e;

  state_e       state_q;
  logic [31:0]  m_q;
  logic [4:0]   p_q;
  logic [4:0]   k_q;
  logic [23:0]  frac_q;
  logic         neg_q;
  logic [58:0]  prod_q;

  logic [30:0]  mul_a, mul_b;
  logic [61:0]  mul_p;
  logic         hit;
  logic [31:0]  sh, nm;
  logic [4:0]   amt;
  logic [31:0]  sq;
  logic [5:0]   lg;
  logic [29:0]  log2v, log2n;
  logic [28:0]  mag;
  logic [28:0]  rnd;

  always_comb begin
    unique case (k_q[2:0])
      3'd0: begin hit = (m_q[31:16] == '0); sh = m_q << 16; amt = 5'd16; end
      3'd1: begin hit = (m_q[31:24] == '0); sh = m_q << 8;  amt = 5'd8;  end
      3'd2: begin hit = (m_q[31:28] == '0); sh = m_q << 4;  amt = 5'd4;  end
      3'd3: begin hit = (m_q[31:30] == '0); sh = m_q << 2;  amt = 5'd2;  end
      default: begin hit = ~m_q[31]; sh = m_q << 1; amt = 5'd1; end
    endcase
    nm = hit ? sh : m_q;
  end

  assign lg    = 6'({1'b0, p_q}) - 6'd16;
  assign log2v = {lg, frac_q};
  assign log2n = 30'd0 - log2v;
  assign mag   = log2v[29] ? log2n[28:0] : log2v[28:0];

  always_comb begin
    if (state_q == L_SCALE) begin
      mul_a = {2'b0, mag};
      mul_b = {1'b0, LN2_Q30};
    end else begin
      mul_a = m_q[30:0];
      mul_b = m_q[30:0];
    end
  end
  assign mul_p = mul_a * mul_b;
  assign sq    = mul_p[61:30];

  assign rnd = 29'((prod_q + 59'(1 << 29)) >> 30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (req_i.start) begin
            m_q     <= (req_i.value == '0) ? 32'd1 : req_i.value;
            p_q     <= 5'd31;
            k_q     <= '0;
            frac_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (hit) p_q <= p_q - amt;
          if (k_q == 5'd4) begin
            m_q     <= nm >> 1;
            k_q     <= 5'(FRAC_STEPS - 1);
            state_q <= L_SQ;
          end else begin
            m_q <= nm;
            k_q <= k_q + 5'd1;
          end
        end
        L_SQ: begin
          m_q    <= sq[31] ? {1'b0, sq[31:1]} : {1'b0, sq[30:0]};
          frac_q <= {frac_q[22:0], sq[31]};
          k_q    <= k_q - 5'd1;
          if (k_q == '0) state_q <= L_SCALE;
        end
        L_SCALE: begin
          prod_q  <= mul_p[58:0];
          neg_q   <= log2v[29];
          state_q <= L_ROUND;
        end
        L_ROUND: begin
          ln_o    <= neg_q ? (LN_W'(0) - LN_W'(rnd)) : LN_W'(rnd);
          done_o  <= 1'b1;
          state_q <= L_IDLE;
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/ppre_div.sv @@
module ppre_div import ppre_pkg::*; #(
  parameter int unsigned NUM_W = COUNT_BITS_DEF,
  parameter int unsigned DEN_W = COUNT_BITS_DEF + 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  localparam int unsigned PAD = DEN_W + 1 - NUM_W - 8;

  typedef enum logic {D_IDLE, D_RUN} state_e;

  state_e           state_q;
  logic [5:0]       cnt_q;
  logic [DEN_W:0]   r_q;
  logic [DEN_W-1:0] d_q;

  logic [DEN_W:0]   numx, rs;
  logic             ge;

  assign numx = {{PAD{1'b0}}, num_i, 8'b0};
  assign rs   = {r_q[DEN_W-1:0], 1'b0};
  assign ge   = rs >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            if (numx >= {1'b0, den_i}) begin
              quo_o  <= '1;
              done_o <= 1'b1;
            end else begin
              r_q     <= (DEN_W + 1)'(num_i);
              d_q     <= den_i;
              quo_o   <= '0;
              cnt_q   <= '0;
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          r_q   <= ge ? rs - {1'b0, d_q} : rs;
          quo_o <= {quo_o[30:0], ge};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd39) begin
            done_o  <= 1'b1;
            state_q <= D_IDLE;
          end
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/piecewise_pareto_rate_estimator_core.sv @@
// Piecewise Pareto rate estimator. func 0 writes a Q16.16 bin edge (slot > NUM_BINS is
// ignored), func 1 adds a sample, func 2 emits one beta per bin in ascending bin order,
// last set on the final bin, then clears counts, log sums, total and the saturation flag.
// Every edge used by a sample or a compute must have been loaded first. An edge load
// does not raise in_stall_o; a sample is held busy by the iterative logarithm
// (5 normalize steps, 24 squaring steps on the shared multiplier, scale and round) that
// runs beside the bin search (one edge memory read per cycle); a compute takes
// ln(edge 0) and then, per bin, a logarithm, two multiplies and a 40-step restoring
// divide. in_stall_o is high while an item is being worked on; a waiting result
// does not hold off the next item except during a compute.
module piecewise_pareto_rate_estimator_core import ppre_pkg::*; #(
  parameter int unsigned NUM_BINS   = NUM_BINS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [4:0]            edge_index_i,
  input  logic [VAL_W-1:0]      value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [3:0]            bin_index_o,
  output logic [31:0]           beta_o,
  output logic [COUNT_BITS-1:0] bin_count_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  localparam int unsigned BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned EA_W   = $clog2(NUM_BINS + 1);
  localparam int unsigned SC_W   = $clog2(NUM_BINS + 2);
  localparam int unsigned LSUM_W = COUNT_BITS + 32;
  localparam int unsigned TOT_W  = COUNT_BITS + 1;
  localparam int unsigned ACC_W  = COUNT_BITS + 34;
  localparam int unsigned DEN_W  = ACC_W - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SWAIT, S_CRD, S_CLN, S_CLW, S_M1, S_M2, S_DIV, S_DWAIT, S_EMIT
  } state_e;

  state_e                     state_q;
  logic [VAL_W-1:0]           edges_q [NUM_BINS+1];
  logic [VAL_W-1:0]           erd_q;
  logic [VAL_W-1:0]           val_q;
  logic [VAL_W-1:0]           lo_q;
  logic [SC_W-1:0]            scan_q;
  logic                       rdv_q;
  logic                       found_q;
  logic [BIN_W-1:0]           fbin_q;
  logic                       ln_rdy_q;
  logic signed [LN_W-1:0]     ln_val_q;
  logic [COUNT_BITS-1:0]      counts_q [NUM_BINS];
  logic signed [LSUM_W-1:0]   lsums_q  [NUM_BINS];
  logic [TOT_W-1:0]           total_q;
  logic                       sat_q;
  logic [BIN_W-1:0]           bin_q;
  logic [EA_W-1:0]            eaddr_q;
  logic                       first_q;
  logic [TOT_W-1:0]           before_q, after_q;
  logic signed [LN_W-1:0]     ln_lo_q, ln_hi_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [31:0]                beta_q;
  logic [1:0]                 stat_q;
  logic                       out_valid_q;

  logic                       acc_in;
  logic [EA_W-1:0]            rd_addr;
  ln_req_t                    ln_req;
  logic                       ln_done;
  logic signed [LN_W-1:0]     ln_res;
  logic                       div_start, div_done;
  logic [31:0]                div_quo;
  logic [TOT_W-1:0]           mul_a;
  logic signed [LN_W-1:0]     mul_b;
  logic signed [ACC_W-1:0]    mul_p;
  logic [COUNT_BITS-1:0]      cur_cnt;
  logic                       hit;
  logic                       out_free;

  assign acc_in     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cur_cnt    = counts_q[bin_q];

  assign rd_addr = (state_q == S_SRCH) ? scan_q[EA_W-1:0] : eaddr_q;

  always_ff @(posedge clk_i) begin
    if (acc_in && func_i == FUNC_LOAD && {27'd0, edge_index_i} <= 32'(NUM_BINS)) begin
      edges_q[EA_W'(edge_index_i)] <= value_i;
    end
    erd_q <= edges_q[rd_addr];
  end

  assign ln_req.start = (acc_in && func_i == FUNC_SAMPLE) || (state_q == S_CLN);
  assign ln_req.value = (state_q == S_CLN) ? erd_q : value_i;

  ppre_ln u_ln (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ln_req),
    .done_o (ln_done),
    .ln_o   (ln_res)
  );

  assign div_start = (state_q == S_DIV) && (acc_q > 0);

  ppre_div #(
    .NUM_W (COUNT_BITS),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cur_cnt),
    .den_i   (acc_q[DEN_W-1:0]),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign mul_a = (state_q == S_M1) ? before_q : after_q;
  assign mul_b = (state_q == S_M1) ? ln_lo_q : ln_hi_q;
  assign mul_p = $signed(ACC_W'({1'b0, mul_a})) * ACC_W'(mul_b);

  assign hit = rdv_q && (scan_q >= SC_W'(2)) && (val_q >= lo_q) && (val_q < erd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ln_rdy_q    <= 1'b0;
      found_q     <= 1'b0;
      rdv_q       <= 1'b0;
      total_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) begin
        counts_q[i] <= '0;
        lsums_q[i]  <= '0;
      end
    end else begin
      if (ln_done) begin
        ln_rdy_q <= 1'b1;
        ln_val_q <= ln_res;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (acc_in) begin
            priority case (func_i)
              FUNC_SAMPLE: begin
                if (total_q == '1) sat_q <= 1'b1;
                else total_q <= total_q + TOT_W'(1);
                val_q    <= value_i;
                scan_q   <= '0;
                rdv_q    <= 1'b0;
                found_q  <= 1'b0;
                ln_rdy_q <= 1'b0;
                state_q  <= S_SRCH;
              end
              FUNC_COMPUTE: begin
                bin_q    <= '0;
                eaddr_q  <= '0;
                before_q <= total_q;
                first_q  <= 1'b1;
                state_q  <= S_CRD;
              end
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          rdv_q  <= 1'b1;
          scan_q <= scan_q + SC_W'(1);
          lo_q   <= erd_q;
          if (hit) begin
            found_q <= 1'b1;
            fbin_q  <= BIN_W'(scan_q - SC_W'(2));
            state_q <= S_SWAIT;
          end else if (rdv_q && scan_q == SC_W'(NUM_BINS + 1)) begin
            state_q <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (ln_rdy_q) begin
            if (found_q) begin
              if (counts_q[fbin_q] == '1) begin
                sat_q <= 1'b1;
              end else begin
                counts_q[fbin_q] <= counts_q[fbin_q] + COUNT_BITS'(1);
                lsums_q[fbin_q]  <= lsums_q[fbin_q] + LSUM_W'(ln_val_q);
              end
            end
            state_q <= S_IDLE;
          end
        end
        S_CRD: state_q <= S_CLN;
        S_CLN: begin
          ln_rdy_q <= 1'b0;
          state_q  <= S_CLW;
        end
        S_CLW: begin
          if (ln_rdy_q) begin
            if (first_q) begin
              ln_lo_q <= ln_val_q;
              first_q <= 1'b0;
              eaddr_q <= eaddr_q + EA_W'(1);
              state_q <= S_CRD;
            end else begin
              ln_hi_q <= ln_val_q;
              after_q <= (before_q > TOT_W'(cur_cnt)) ? before_q - TOT_W'(cur_cnt) : '0;
              state_q <= S_M1;
            end
          end
        end
        S_M1: begin
          acc_q   <= ACC_W'(lsums_q[bin_q]) - mul_p;
          state_q <= S_M2;
        end
        S_M2: begin
          acc_q   <= acc_q + mul_p;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (acc_q > 0) begin
            state_q <= S_DWAIT;
          end else begin
            beta_q  <= '1;
            stat_q  <= ST_DEN;
            state_q <= S_EMIT;
          end
        end
        S_DWAIT: begin
          if (div_done) begin
            beta_q  <= div_quo;
            stat_q  <= sat_q ? ST_SAT : ST_OK;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            bin_index_o <= 4'(bin_q);
            beta_o      <= beta_q;
            bin_count_o <= cur_cnt;
            status_o    <= stat_q;
            last_o      <= (bin_q == BIN_W'(NUM_BINS - 1));
            before_q    <= after_q;
            ln_lo_q     <= ln_hi_q;
            if (bin_q == BIN_W'(NUM_BINS - 1)) begin
              total_q <= '0;
              sat_q   <= 1'b0;
              for (int i = 0; i < NUM_BINS; i++) begin
                counts_q[i] <= '0;
                lsums_q[i]  <= '0;
              end
              state_q <= S_IDLE;
            end else begin
              bin_q   <= bin_q + BIN_W'(1);
              eaddr_q <= eaddr_q + EA_W'(1);
              state_q <= S_CRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("result appeared outside emit");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DWAIT)
    else $error("divider finished with nobody waiting");

  a_ln_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_done |-> state_q != S_IDLE)
    else $error("logarithm finished while idle");

  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> bin_index_o == 4'(NUM_BINS - 1))
    else $error("last flag on wrong bin");
`endif

endmodule

@@ bench/testbench.sv @@
module testbench;
  import ppre_pkg::*;

  localparam int unsigned NB = NUM_BINS_DEF;
  localparam int unsigned CB = COUNT_BITS_DEF;
  localparam longint unsigned COUNT_MAX = (64'd1 << CB) - 1;
  localparam longint unsigned TOTAL_MAX = (64'd1 << (CB + 1)) - 1;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  idx;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]    bin;
    logic [31:0]   beta;
    logic [CB-1:0] count;
    logic [1:0]    status;
    logic          last;
  } estimate_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic [4:0] edge_index_i = '0;
  logic [31:0] value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] bin_index_o;
  logic [31:0] beta_o;
  logic [CB-1:0] bin_count_o;
  logic [1:0] status_o;
  logic last_o;

  cmd_t      cmd_queue[$];
  estimate_t estimate_queue[$];
  int        mismatches = 0;
  logic      in_fire = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  bit        calm = 1'b0;

  logic [31:0]     edges[NB+1];
  longint unsigned counts[NB];
  longint          log_sums[NB];
  longint unsigned total;
  bit              sat_flag;

  piecewise_pareto_rate_estimator_core u_dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint ln_q24(logic [31:0] v);
    int p;
    longint unsigned m, frac, mag;
    longint l2;
    if (v == 0) v = 1;
    p = 31;
    while (!v[p]) p--;
    m = (p <= 30) ? (longint'(v) << (30 - p)) : (longint'(v) >> 1);
    frac = 0;
    for (int k = 23; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 64'd1 << k;
      end
    end
    l2 = longint'(p - 16) * 16777216 + longint'(frac);
    mag = ((l2 < 0) ? -l2 : l2) * 64'd744261118;
    mag = (mag + (64'd1 << 29)) >> 30;
    return (l2 < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [31:0] beta_div(longint unsigned c, longint unsigned d);
    longint unsigned r, q;
    r = c;
    q = 0;
    if ((c << 8) >= d) return 32'hFFFF_FFFF;
    for (int k = 0; k < 40; k++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    return q[31:0];
  endfunction

  function automatic void clear_stats();
    for (int j = 0; j < NB; j++) begin
      counts[j] = 0;
      log_sums[j] = 0;
    end
    total = 0;
    sat_flag = 0;
  endfunction

  function automatic void estimate_apply(cmd_t c);
    longint unsigned rem_before, after;
    longint lo, hi, d;
    estimate_t e;
    case (c.func)
      FUNC_LOAD: begin
        if (c.idx <= NB) edges[c.idx] = c.value;
      end
      FUNC_SAMPLE: begin
        if (total >= TOTAL_MAX) sat_flag = 1;
        else total++;
        for (int j = 0; j < NB; j++) begin
          if (c.value >= edges[j] && c.value < edges[j+1]) begin
            if (counts[j] >= COUNT_MAX) begin
              sat_flag = 1;
            end else begin
              counts[j]++;
              log_sums[j] += ln_q24(c.value);
            end
            break;
          end
        end
      end
      FUNC_COMPUTE: begin
        rem_before = total;
        lo = ln_q24(edges[0]);
        for (int j = 0; j < NB; j++) begin
          after = (rem_before > counts[j]) ? rem_before - counts[j] : 0;
          hi = ln_q24(edges[j+1]);
          d = log_sums[j] + longint'(after) * hi - longint'(rem_before) * lo;
          e.bin = 4'(j);
          e.count = CB'(counts[j]);
          e.last = (j == NB - 1);
          if (d <= 0) begin
            e.beta = 32'hFFFF_FFFF;
            e.status = ST_DEN;
          end else begin
            e.beta = beta_div(counts[j], longint'(d));
            e.status = sat_flag ? ST_SAT : ST_OK;
          end
          estimate_queue.push_back(e);
          rem_before = after;
          lo = hi;
        end
        clear_stats();
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void push(logic [1:0] f, logic [4:0] i, logic [31:0] v);
    cmd_t c;
    c.func = f;
    c.idx = i;
    c.value = v;
    cmd_queue.push_back(c);
  endfunction

  function automatic void push_noise();
    if ($urandom_range(0, 1)) push(FUNC_NONE, 5'($urandom), $urandom);
    else push(FUNC_LOAD, 5'($urandom_range(NB + 1, 31)), $urandom);
  endfunction

  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
    if (!in_valid_i || in_fire) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (cmd_queue.size() > 0 && rst_ni) begin
        in_valid_i <= 1'b1;
        func_i <= cmd_queue[0].func;
        edge_index_i <= cmd_queue[0].idx;
        value_i <= cmd_queue[0].value;
        void'(cmd_queue.pop_front());
        in_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    if (out_gap > 0) begin
      out_stall_i <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall_i <= 1'b0;
      out_gap <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cmd_t c;
    estimate_t e;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      c.func = func_i;
      c.idx = edge_index_i;
      c.value = value_i;
      estimate_apply(c);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (estimate_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: bin %0d beta %h", bin_index_o, beta_o);
      end else begin
        e = estimate_queue.pop_front();
        if (bin_index_o !== e.bin || beta_o !== e.beta || bin_count_o !== e.count ||
            status_o !== e.status || last_o !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp bin %0d beta %h count %0d status %0d last %0d,",
                      " got %0d %h %0d %0d %0d"},
                     e.bin, e.beta, e.count, e.status, e.last,
                     bin_index_o, beta_o, bin_count_o, status_o, last_o);
        end
      end
    end
  end

  initial begin
    logic [31:0] ev[$];
    int n, j, ns;
    logic [31:0] lo, hi;
    for (int k = 0; k <= NB; k++) edges[k] = 0;
    clear_stats();
    for (int k = 0; k <= NB; k++)
      push(FUNC_LOAD, 5'(k),
           (k == 0) ? 32'd1 : (k == NB) ? 32'hFFFF_FFFF : 32'h0000_8000 << (k - 1));
    push(FUNC_COMPUTE, '0, '0);
    push(FUNC_SAMPLE, '0, 32'd0);
    push(FUNC_SAMPLE, '0, 32'd1);
    push(FUNC_SAMPLE, '0, 32'hFFFF_FFFE);
    push(FUNC_SAMPLE, '0, 32'hFFFF_FFFF);
    push(FUNC_SAMPLE, '0, 32'h0001_0000);
    push(FUNC_SAMPLE, '0, 32'h00AA_5555);
    push(FUNC_LOAD, 5'(NB + 1), 32'h1234_5678);
    push(FUNC_LOAD, 5'd31, 32'h0);
    push(FUNC_NONE, 5'd5, 32'h5555_AAAA);
    push(FUNC_COMPUTE, '0, '0);
    push(FUNC_LOAD, '0, 32'h0001_0000);
    push(FUNC_SAMPLE, '0, 32'h0000_8000);
    push(FUNC_SAMPLE, '0, 32'h0001_0000);
    push(FUNC_COMPUTE, '0, '0);
    n = cmd_queue.size();
    while (n < 420) begin
      ev.delete();
      for (int k = 0; k <= NB; k++) ev.push_back(($urandom >> $urandom_range(0, 31)) | 32'd1);
      if ($urandom_range(0, 7) != 0) ev.sort();
      for (int k = 0; k <= NB; k++) begin
        push(FUNC_LOAD, 5'(k), ev[k]);
        if ($urandom_range(0, 19) == 0) push_noise();
      end
      ns = $urandom_range(3, 30);
      for (int s = 0; s < ns; s++) begin
        j = $urandom_range(0, NB - 1);
        lo = ev[j];
        hi = ev[j+1];
        if ($urandom_range(0, 19) == 0) push_noise();
        if ($urandom_range(0, 4) != 0 && hi > lo)
          push(FUNC_SAMPLE, '0, lo + $urandom_range(0, hi - lo - 1));
        else
          push(FUNC_SAMPLE, '0, $urandom >> $urandom_range(0, 8));
      end
      push(FUNC_COMPUTE, '0, '0);
      n += ns + NB + 2;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (cmd_queue.size() == 0 && !in_valid_i && estimate_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && estimate_queue.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(8 * 1_500_000);
    $display("end of test: mismatches");
    $finish;
  end
endmodule

@@ piecewise_pareto_rate_estimator_core.f @@
rtl/core/ppre_pkg.sv
rtl/core/ppre_ln.sv
rtl/core/ppre_div.sv
rtl/core/piecewise_pareto_rate_estimator_core.sv
bench/testbench.sv
